### rtl/lattice_basis_shortener_3d_top_defines.svh
// Assertion helpers shared by the RTL of the lattice basis shortener.
`ifndef LATTICE_BASIS_SHORTENER_3D_TOP_DEFINES_SVH
`define LATTICE_BASIS_SHORTENER_3D_TOP_DEFINES_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define LBS_ASSERT_HOLD(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define LBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lbs3d_pkg.sv
`timescale 1ns / 1ps

package lbs3d_pkg;

    localparam int DEF_COMP_WIDTH = 32;
    localparam int LIMIT_W        = 6;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 6'd20;

    // |ab|/b2 + 0.499 is evaluated as (1000*|ab| + 499*b2) / (1000*b2)
    localparam int K_SCALE = 1000;
    localparam int K_ROUND = 499;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHK   = 10'b0000000010,
        S_DOT   = 10'b0000000100,
        S_SETUP = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_UPD   = 10'b0000100000,
        S_JK    = 10'b0001000000,
        S_TSET  = 10'b0010000000,
        S_NEXT  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

endpackage

### rtl/lattice_basis_shortener_3d_top.sv
`timescale 1ns / 1ps
// Lattice basis shortener, three vectors in three dimensions.
// Command channel: drive the nine components and pulse start while busy is low;
// the basis is captured at that edge and busy stays high until the result.
// Result channel: o_valid is high for one cycle with the reduced vectors and
// o_limit_hit on the result ports; the receiver cannot stall it, so the result
// must be taken in that cycle. busy falls the cycle after o_valid.
// Config channel: i_cfg_valid/o_cfg_ready write the pass limit (6 bits);
// o_cfg_ready is always high. Write it only while busy is low.
// Datapath: one shared 34x34 multiplier and a one-bit-per-cycle restoring
// divider do all the work. A reduction that does not fire runs the dot
// products, setup and step; one that fires also runs the divide and update.
// Each vector per pass adds a cross-term step and each pass adds one check
// step. One item at a time.
// Reset: returns to idle, pass limit goes back to 20, no result pending.
`include "lattice_basis_shortener_3d_top_defines.svh"

module lattice_basis_shortener_3d_top
    import lbs3d_pkg::*;
#(
    parameter int COMP_WIDTH = DEF_COMP_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COMP_WIDTH-1:0] i_a_x,
    input  logic signed [COMP_WIDTH-1:0] i_a_y,
    input  logic signed [COMP_WIDTH-1:0] i_a_z,
    input  logic signed [COMP_WIDTH-1:0] i_b_x,
    input  logic signed [COMP_WIDTH-1:0] i_b_y,
    input  logic signed [COMP_WIDTH-1:0] i_b_z,
    input  logic signed [COMP_WIDTH-1:0] i_c_x,
    input  logic signed [COMP_WIDTH-1:0] i_c_y,
    input  logic signed [COMP_WIDTH-1:0] i_c_z,
    output logic                         o_valid,
    output logic signed [COMP_WIDTH-1:0] o_ra_x,
    output logic signed [COMP_WIDTH-1:0] o_ra_y,
    output logic signed [COMP_WIDTH-1:0] o_ra_z,
    output logic signed [COMP_WIDTH-1:0] o_rb_x,
    output logic signed [COMP_WIDTH-1:0] o_rb_y,
    output logic signed [COMP_WIDTH-1:0] o_rb_z,
    output logic signed [COMP_WIDTH-1:0] o_rc_x,
    output logic signed [COMP_WIDTH-1:0] o_rc_y,
    output logic signed [COMP_WIDTH-1:0] o_rc_z,
    output logic                         o_limit_hit,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [LIMIT_W-1:0]           i_cfg_data
);

    localparam int CW  = COMP_WIDTH;
    localparam int TW  = CW + 1;          // cross vector component
    localparam int MW  = CW + 2;          // multiplier operand
    localparam int PW  = 2 * MW;          // multiplier product
    localparam int DW  = 2 * CW + 3;      // dot product
    localparam int NW  = 2 * CW + 13;     // scaled numerator / denominator
    localparam int QB  = CW + 2;          // quotient bits below the overflow bit
    localparam int SHW = NW + CW + 2;     // shifted divisor
    localparam int BW  = $clog2(CW + 3);

    localparam logic [BW-1:0] BIT_TOP = BW'(CW + 2);
    localparam logic [CW:0]   CAP     = {1'b1, {CW{1'b0}}};
    localparam logic signed [PW:0] SMAX = {{(PW - CW + 2){1'b0}}, {(CW - 1){1'b1}}};
    localparam logic signed [PW:0] SMIN = {{(PW - CW + 2){1'b1}}, {(CW - 1){1'b0}}};

    // slot 0 is the vector under reduction; slots rotate once per vector
    logic signed [CW-1:0] r_s0 [3];
    logic signed [CW-1:0] r_s1 [3];
    logic signed [CW-1:0] r_s2 [3];
    logic signed [TW-1:0] r_t  [3];

    t_state               r_state;
    logic [2:0]           r_step;
    logic [1:0]           r_i;
    logic [1:0]           r_tgt;
    logic [LIMIT_W-1:0]   r_iter;
    logic [LIMIT_W-1:0]   r_limit;
    logic                 r_last_nz;
    logic                 r_hit;
    logic signed [DW-1:0] r_ab;
    logic signed [DW-1:0] r_b2;
    logic signed [PW-1:0] r_prod;
    logic [NW-1:0]        r_num;
    logic [SHW-1:0]       r_dsh;
    logic [QB-1:0]        r_q;
    logic [CW:0]          r_n;
    logic                 r_sub;
    logic [BW-1:0]        r_bit;

    logic [1:0]           cidx;
    logic [1:0]           kidx;
    logic signed [TW-1:0] opv [3];
    logic signed [TW-1:0] op_c;
    logic signed [CW-1:0] s0_c, s1_c, s2_c, s0_k;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [DW-1:0] prod_dw;
    logic signed [DW:0]   two_ab, neg_two_ab, b2_x;
    logic                 fire_sub, fire_add;
    logic [NW-1:0]        mag_u, b2_u, num_c, den_c;
    logic                 div_ge;
    logic [QB-1:0]        q_fin;
    logic signed [PW:0]   upd_sum;
    logic signed [CW-1:0] upd_sat;

    assign cidx = (r_step >= 3'd3) ? 2'(r_step - 3'd3) : r_step[1:0];
    assign kidx = 2'(r_step - 3'd1);

    // operand vector: first other vector, second other vector, then cross term
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_tgt == 2'd2) begin
                opv[c] = r_t[c];
            end else if ((r_tgt == 2'd0) ^ (r_i == 2'd1)) begin
                opv[c] = TW'(r_s1[c]);
            end else begin
                opv[c] = TW'(r_s2[c]);
            end
        end
    end

    always_comb begin
        unique case (cidx)
            2'd0: begin
                op_c = opv[0]; s0_c = r_s0[0]; s1_c = r_s1[0]; s2_c = r_s2[0];
            end
            2'd1: begin
                op_c = opv[1]; s0_c = r_s0[1]; s1_c = r_s1[1]; s2_c = r_s2[1];
            end
            default: begin
                op_c = opv[2]; s0_c = r_s0[2]; s1_c = r_s1[2]; s2_c = r_s2[2];
            end
        endcase
        unique case (kidx)
            2'd0:    s0_k = r_s0[0];
            2'd1:    s0_k = r_s0[1];
            default: s0_k = r_s0[2];
        endcase
    end

    // shared multiplier operands
    always_comb begin
        unique case (r_state)
            S_DOT: begin
                mul_a = (r_step < 3'd3) ? MW'(s0_c) : MW'(op_c);
                mul_b = MW'(op_c);
            end
            S_UPD: begin
                mul_a = {1'b0, r_n};
                mul_b = MW'(op_c);
            end
            S_JK: begin
                mul_a = MW'(s1_c);
                mul_b = MW'(s2_c);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_dw = r_prod[DW-1:0];

    assign two_ab     = {r_ab, 1'b0};
    assign neg_two_ab = -two_ab;
    assign b2_x       = (DW + 1)'(r_b2);
    assign fire_sub   = two_ab > b2_x;
    assign fire_add   = neg_two_ab > b2_x;
    assign mag_u      = fire_sub ? NW'(r_ab) : NW'(-r_ab);
    assign b2_u       = NW'(r_b2);
    assign num_c      = mag_u * NW'(K_SCALE) + b2_u * NW'(K_ROUND);
    assign den_c      = b2_u * NW'(K_SCALE);

    assign div_ge = {{(SHW - NW){1'b0}}, r_num} >= r_dsh;
    assign q_fin  = {r_q[QB-2:0], div_ge};

    always_comb begin
        upd_sum = r_sub ? ((PW + 1)'(s0_k) - (PW + 1)'(r_prod))
                        : ((PW + 1)'(s0_k) + (PW + 1)'(r_prod));
        if (upd_sum > SMAX) begin
            upd_sat = SMAX[CW-1:0];
        end else if (upd_sum < SMIN) begin
            upd_sat = SMIN[CW-1:0];
        end else begin
            upd_sat = upd_sum[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= LIMIT_RST;
            r_hit   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_s0[0] <= i_a_x; r_s0[1] <= i_a_y; r_s0[2] <= i_a_z;
                        r_s1[0] <= i_b_x; r_s1[1] <= i_b_y; r_s1[2] <= i_b_z;
                        r_s2[0] <= i_c_x; r_s2[1] <= i_c_y; r_s2[2] <= i_c_z;
                        r_iter    <= '0;
                        r_last_nz <= 1'b1;
                        r_state   <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_last_nz && (r_iter < r_limit)) begin
                        r_iter    <= r_iter + 1'b1;
                        r_last_nz <= 1'b0;
                        r_i       <= 2'd0;
                        r_tgt     <= 2'd0;
                        r_step    <= 3'd0;
                        r_state   <= S_DOT;
                    end else begin
                        r_hit   <= r_iter >= r_limit;
                        r_state <= S_DONE;
                    end
                end
                S_DOT: begin
                    // accumulate the product issued in the previous step
                    if (r_step == 3'd1) begin
                        r_ab <= prod_dw;
                    end else if (r_step == 3'd2 || r_step == 3'd3) begin
                        r_ab <= r_ab + prod_dw;
                    end else if (r_step == 3'd4) begin
                        r_b2 <= prod_dw;
                    end else if (r_step != 3'd0) begin
                        r_b2 <= r_b2 + prod_dw;
                    end
                    if (r_step == 3'd6) begin
                        r_step  <= 3'd0;
                        r_state <= S_SETUP;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_SETUP: begin
                    if (fire_sub || fire_add) begin
                        r_sub   <= fire_sub;
                        r_num   <= num_c;
                        r_dsh   <= SHW'(den_c) << (CW + 2);
                        r_q     <= '0;
                        r_bit   <= BIT_TOP;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_DIV: begin
                    if (div_ge) begin
                        r_num <= r_num - r_dsh[NW-1:0];
                    end
                    r_dsh <= r_dsh >> 1;
                    r_q   <= q_fin;
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == BIT_TOP && div_ge) begin
                        // quotient far above the cap
                        r_n       <= CAP;
                        r_last_nz <= 1'b1;
                        r_step    <= 3'd0;
                        r_state   <= S_UPD;
                    end else if (r_bit == '0) begin
                        r_n       <= (q_fin > QB'(CAP)) ? CAP : q_fin[CW:0];
                        r_last_nz <= q_fin != '0;
                        r_step    <= 3'd0;
                        r_state   <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_step != 3'd0) begin
                        unique case (kidx)
                            2'd0:    r_s0[0] <= upd_sat;
                            2'd1:    r_s0[1] <= upd_sat;
                            default: r_s0[2] <= upd_sat;
                        endcase
                    end
                    if (r_step == 3'd3) begin
                        r_step  <= 3'd0;
                        r_state <= S_NEXT;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_JK: begin
                    if (r_step == 3'd1) begin
                        r_ab <= prod_dw;
                    end else if (r_step != 3'd0) begin
                        r_ab <= r_ab + prod_dw;
                    end
                    if (r_step == 3'd3) begin
                        r_step  <= 3'd0;
                        r_state <= S_TSET;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_TSET: begin
                    for (int c = 0; c < 3; c++) begin
                        r_t[c] <= (r_ab > 0) ? (TW'(r_s1[c]) - TW'(r_s2[c]))
                                             : (TW'(r_s1[c]) + TW'(r_s2[c]));
                    end
                    r_tgt   <= 2'd2;
                    r_step  <= 3'd0;
                    r_state <= S_DOT;
                end
                S_NEXT: begin
                    r_step <= 3'd0;
                    unique case (r_tgt)
                        2'd0: begin
                            r_tgt   <= 2'd1;
                            r_state <= S_DOT;
                        end
                        2'd1: begin
                            r_state <= S_JK;
                        end
                        default: begin
                            // advance to the next vector: rotate the slots
                            r_s0  <= r_s1;
                            r_s1  <= r_s2;
                            r_s2  <= r_s0;
                            r_tgt <= 2'd0;
                            if (r_i == 2'd2) begin
                                r_state <= S_CHK;
                            end else begin
                                r_i     <= r_i + 2'd1;
                                r_state <= S_DOT;
                            end
                        end
                    endcase
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = r_state != S_IDLE;
    assign o_valid     = r_state == S_DONE;
    assign o_cfg_ready = 1'b1;
    assign o_limit_hit = r_hit;
    assign o_ra_x = r_s0[0];
    assign o_ra_y = r_s0[1];
    assign o_ra_z = r_s0[2];
    assign o_rb_x = r_s1[0];
    assign o_rb_y = r_s1[1];
    assign o_rb_z = r_s1[2];
    assign o_rc_x = r_s2[0];
    assign o_rc_y = r_s2[1];
    assign o_rc_z = r_s2[2];

    `LBS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `LBS_ASSERT_NEXT(a_done_idle, o_valid, !busy && !o_valid, "result strobe not followed by idle")
    `LBS_ASSERT_HOLD(a_n_capped, r_state == S_UPD, r_n <= CAP, "multiplier above its cap")
    `LBS_ASSERT_HOLD(a_valid_after_busy, o_valid, $past(busy), "result without a running transaction")

endmodule
